// ----- rtl/core/point_in_polygon_parity_assert.svh -----
`ifndef POINT_IN_POLYGON_PARITY_ASSERT_SVH
`define POINT_IN_POLYGON_PARITY_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PIP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("point_in_polygon_parity: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PIP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("point_in_polygon_parity: assertion failed");

`endif

// ----- rtl/core/pip_pkg.sv -----
package pip_pkg;

   // Width of the coordinate fields on the ports.
   localparam int FIELD_BITS = 32;

   // Edge queue between front and back.
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_ADDR_BITS  = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   // Per-item control that travels with the vertex through the queue.
   typedef struct packed {
      logic has_prev;   // an edge from the previous vertex exists
      logic last;       // closes the ring, yields a result
   } task_ctl_type;

endpackage

// ----- rtl/core/pip_queue.sv -----
`include "point_in_polygon_parity_assert.svh"

module pip_queue #(
   parameter int DATA_BITS = 192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pip_pkg::task_ctl_type push_ctl,
   input  logic [DATA_BITS-1:0]  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output pip_pkg::task_ctl_type head_ctl,
   output logic [DATA_BITS-1:0]  head_data
);

   pip_pkg::task_ctl_type ctl_ff [pip_pkg::QUEUE_DEPTH];
   logic [DATA_BITS-1:0]  data_ff [pip_pkg::QUEUE_DEPTH];

   logic [pip_pkg::QUEUE_ADDR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pip_pkg::QUEUE_ADDR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pip_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign full       = (count_ff == pip_pkg::QUEUE_COUNT_BITS'(pip_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_ctl   = ctl_ff[rd_ptr_ff];
   assign head_data  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]  <= push_ctl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PIP_ASSERT_SAME(a_no_push_when_full, push, !full || pop)
   `PIP_ASSERT_SAME(a_no_pop_when_empty, pop, head_valid)

endmodule

// ----- rtl/core/pip_front.sv -----
module pip_front #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic [pip_pkg::FIELD_BITS-1:0] vertex_x,
   input  logic [pip_pkg::FIELD_BITS-1:0] vertex_y,
   input  logic                           last_vertex,
   input  logic                           queue_full,
   output logic                           push,
   output pip_pkg::task_ctl_type          push_ctl,
   output logic [COORD_BITS-1:0]          prev_x,
   output logic [COORD_BITS-1:0]          prev_y,
   output logic [COORD_BITS-1:0]          cur_x,
   output logic [COORD_BITS-1:0]          cur_y,
   output logic [COORD_BITS-1:0]          first_x,
   output logic [COORD_BITS-1:0]          first_y
);

   logic [COORD_BITS-1:0] first_x_ff, first_x_in;
   logic [COORD_BITS-1:0] first_y_ff, first_y_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                  started_ff, started_in;

   assign in_stall = queue_full;
   assign push     = in_valid && !queue_full;
   assign cur_x    = vertex_x[COORD_BITS-1:0];
   assign cur_y    = vertex_y[COORD_BITS-1:0];

   always_comb begin
      push_ctl.has_prev = started_ff;
      push_ctl.last     = last_vertex;
      prev_x  = prev_x_ff;
      prev_y  = prev_y_ff;
      // A fresh ring closes onto the vertex itself.
      first_x = started_ff ? first_x_ff : cur_x;
      first_y = started_ff ? first_y_ff : cur_y;

      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      started_in = started_ff;
      if (push) begin
         first_x_in = first_x;
         first_y_in = first_y;
         prev_x_in  = cur_x;
         prev_y_in  = cur_y;
         started_in = !last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
   end

endmodule

// ----- rtl/core/pip_back.sv -----
`include "point_in_polygon_parity_assert.svh"

module pip_back #(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   input  logic                  head_valid,
   input  pip_pkg::task_ctl_type head_ctl,
   input  logic [COORD_BITS-1:0] prev_x,
   input  logic [COORD_BITS-1:0] prev_y,
   input  logic [COORD_BITS-1:0] cur_x,
   input  logic [COORD_BITS-1:0] cur_y,
   input  logic [COORD_BITS-1:0] first_x,
   input  logic [COORD_BITS-1:0] first_y,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic                  inside_res
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int LANES     = 2;

   // Lane 0: edge from previous vertex to this one. Lane 1: closing edge.
   logic signed [COORD_BITS-1:0] x1 [LANES];
   logic signed [COORD_BITS-1:0] y1 [LANES];
   logic signed [COORD_BITS-1:0] x2 [LANES];
   logic signed [COORD_BITS-1:0] y2 [LANES];
   logic signed [COORD_BITS-1:0] px, py;

   logic                         advance;

   logic                         s1_valid_ff, s1_valid_in;
   pip_pkg::task_ctl_type        s1_ctl_ff;
   logic [LANES-1:0]             s1_cross_ff, s1_cross_in;
   logic [LANES-1:0]             s1_up_ff, s1_up_in;
   logic signed [DIFF_BITS-1:0]  s1_dpx_ff [LANES], s1_dpx_in [LANES];
   logic signed [DIFF_BITS-1:0]  s1_dy_ff [LANES], s1_dy_in [LANES];
   logic signed [DIFF_BITS-1:0]  s1_dpy_ff [LANES], s1_dpy_in [LANES];
   logic signed [DIFF_BITS-1:0]  s1_dx_ff [LANES], s1_dx_in [LANES];

   logic                         s2_valid_ff;
   pip_pkg::task_ctl_type        s2_ctl_ff;
   logic [LANES-1:0]             s2_cross_ff;
   logic [LANES-1:0]             s2_up_ff;
   logic signed [PROD_BITS-1:0]  s2_lhs_ff [LANES], s2_lhs_in [LANES];
   logic signed [PROD_BITS-1:0]  s2_rhs_ff [LANES], s2_rhs_in [LANES];

   logic [LANES-1:0]             toggle;
   logic                         parity_ff, parity_in;
   logic                         parity_next;
   logic                         out_valid_ff, out_valid_in;
   logic                         inside_ff, inside_in;

   // Whole back end holds while a result waits at the output.
   assign advance    = !out_valid_ff || !out_stall;
   assign pop        = advance && head_valid;
   assign out_valid  = out_valid_ff;
   assign inside_res = inside_ff;

   assign px = $signed(point_x);
   assign py = $signed(point_y);

   // Stage 1: crossing test and differences.
   always_comb begin
      x1[0] = $signed(prev_x);
      y1[0] = $signed(prev_y);
      x2[0] = $signed(cur_x);
      y2[0] = $signed(cur_y);
      x1[1] = $signed(cur_x);
      y1[1] = $signed(cur_y);
      x2[1] = $signed(first_x);
      y2[1] = $signed(first_y);
      s1_valid_in = advance ? pop : s1_valid_ff;
      for (int i = 0; i < LANES; i++) begin
         s1_up_in[i]    = (y1[i] <= py) && (y2[i] > py);
         s1_cross_in[i] = s1_up_in[i] || ((y1[i] > py) && (y2[i] <= py));
         s1_dpx_in[i]   = $signed({px[COORD_BITS-1], px}) - $signed({x1[i][COORD_BITS-1], x1[i]});
         s1_dy_in[i]    = $signed({y2[i][COORD_BITS-1], y2[i]}) - $signed({y1[i][COORD_BITS-1], y1[i]});
         s1_dpy_in[i]   = $signed({py[COORD_BITS-1], py}) - $signed({y1[i][COORD_BITS-1], y1[i]});
         s1_dx_in[i]    = $signed({x2[i][COORD_BITS-1], x2[i]}) - $signed({x1[i][COORD_BITS-1], x1[i]});
      end
      // No edge into the first vertex of a ring.
      s1_cross_in[0] = s1_cross_in[0] && head_ctl.has_prev;
      // Closing edge exists only on the last vertex.
      s1_cross_in[1] = s1_cross_in[1] && head_ctl.last;
   end

   // Stage 2: the two cross products of each lane.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s2_lhs_in[i] = s1_dpx_ff[i] * s1_dy_ff[i];
         s2_rhs_in[i] = s1_dpy_ff[i] * s1_dx_ff[i];
      end
   end

   // Stage 3: compare, fold into parity, load the result.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         toggle[i] = s2_cross_ff[i] &&
                     (s2_up_ff[i] ? (s2_lhs_ff[i] < s2_rhs_ff[i])
                                  : (s2_rhs_ff[i] < s2_lhs_ff[i]));
      end
      parity_next  = (s2_ctl_ff.has_prev && parity_ff) ^ toggle[0] ^ toggle[1];
      parity_in    = parity_ff;
      out_valid_in = out_valid_ff;
      inside_in    = inside_ff;
      if (advance) begin
         out_valid_in = s2_valid_ff && s2_ctl_ff.last;
         if (s2_valid_ff) begin
            parity_in = s2_ctl_ff.last ? 1'b0 : parity_next;
            inside_in = parity_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         parity_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
         parity_ff    <= parity_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      if (advance) begin
         s1_ctl_ff   <= head_ctl;
         s1_cross_ff <= s1_cross_in;
         s1_up_ff    <= s1_up_in;
         s1_dpx_ff   <= s1_dpx_in;
         s1_dy_ff    <= s1_dy_in;
         s1_dpy_ff   <= s1_dpy_in;
         s1_dx_ff    <= s1_dx_in;
         s2_ctl_ff   <= s1_ctl_ff;
         s2_cross_ff <= s1_cross_ff;
         s2_up_ff    <= s1_up_ff;
         s2_lhs_ff   <= s2_lhs_in;
         s2_rhs_ff   <= s2_rhs_in;
      end
   end

   `PIP_ASSERT_NEXT(a_close_gives_result, advance && s2_valid_ff && s2_ctl_ff.last, out_valid_ff)
   `PIP_ASSERT_NEXT(a_close_clears_parity, advance && s2_valid_ff && s2_ctl_ff.last, !parity_ff)

endmodule

// ----- rtl/core/point_in_polygon_parity.sv -----
// Point-in-polygon test by crossing parity (even-odd rule). Load the test point
// through the APB registers point_x (byte address 0) and point_y (byte address 4),
// then stream the polygon's vertices one item per cycle on the req_ channel, with
// req_last_vertex set on the final vertex of each ring. Each edge whose y range
// crosses the point's y under the half-open rule toggles the parity when the point
// lies strictly left of the edge; the test uses exact cross products, so ties on
// an edge follow exact integer arithmetic. The last vertex also closes the ring
// back to the first vertex, and one item with rsp_inside_res (1 = inside) comes
// out; no other vertex produces an item. The block then rearms for the next ring.
// Throughput is one vertex per cycle while req_stall is low; the edge into the
// vertex and the closing edge are computed side by side in two lanes of two
// 33x33 multipliers each. A result passes through the queue, the stage-1, product
// and output registers. A four-entry queue separates the vertex front end from
// the arithmetic, so while rsp_stall holds the result, up to four more vertices
// are still taken before req_stall rises. Coordinates use the low COORD_BITS bits
// of each field as two's complement; write the registers only while idle.
module point_in_polygon_parity #(
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // vertex items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_vertex_x,
   input  logic [31:0] req_vertex_y,
   input  logic        req_last_vertex,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_inside_res,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int          CSR_DATA_BITS = 32;
   localparam int          TASK_BITS     = 6 * COORD_BITS;
   localparam logic        REG_POINT_X   = 1'b0;
   localparam logic        REG_POINT_Y   = 1'b1;

   logic [COORD_BITS-1:0]  point_x_ff, point_x_in;
   logic [COORD_BITS-1:0]  point_y_ff, point_y_in;
   logic                   csr_write;
   logic                   csr_sel;

   logic                   push;
   logic                   queue_full;
   pip_pkg::task_ctl_type  push_ctl;
   logic [COORD_BITS-1:0]  f_prev_x, f_prev_y, f_cur_x, f_cur_y, f_first_x, f_first_y;
   logic [TASK_BITS-1:0]   push_data;

   logic                   pop;
   logic                   head_valid;
   pip_pkg::task_ctl_type  head_ctl;
   logic [TASK_BITS-1:0]   head_data;

   // Register port: always ready, word select on address bit 2.
   assign pready    = 1'b1;
   assign csr_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      unique case (csr_sel)
         REG_POINT_X: begin
            prdata = CSR_DATA_BITS'($signed(point_x_ff));
            if (csr_write) begin
               point_x_in = pwdata[COORD_BITS-1:0];
            end
         end
         REG_POINT_Y: begin
            prdata = CSR_DATA_BITS'($signed(point_y_ff));
            if (csr_write) begin
               point_y_in = pwdata[COORD_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
      end else begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
      end
   end

   // Front end: track the ring and turn each vertex into edge work.
   pip_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .vertex_x    (req_vertex_x),
      .vertex_y    (req_vertex_y),
      .last_vertex (req_last_vertex),
      .queue_full  (queue_full),
      .push        (push),
      .push_ctl    (push_ctl),
      .prev_x      (f_prev_x),
      .prev_y      (f_prev_y),
      .cur_x       (f_cur_x),
      .cur_y       (f_cur_y),
      .first_x     (f_first_x),
      .first_y     (f_first_y)
   );

   assign push_data = {f_prev_x, f_prev_y, f_cur_x, f_cur_y, f_first_x, f_first_y};

   // Decouple front and back so each side stalls on its own.
   pip_queue #(
      .DATA_BITS (TASK_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_ctl   (head_ctl),
      .head_data  (head_data)
   );

   // Back end: crossing tests, cross products, parity and result.
   pip_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .point_x    (point_x_ff),
      .point_y    (point_y_ff),
      .head_valid (head_valid),
      .head_ctl   (head_ctl),
      .prev_x     (head_data[6*COORD_BITS-1:5*COORD_BITS]),
      .prev_y     (head_data[5*COORD_BITS-1:4*COORD_BITS]),
      .cur_x      (head_data[4*COORD_BITS-1:3*COORD_BITS]),
      .cur_y      (head_data[3*COORD_BITS-1:2*COORD_BITS]),
      .first_x    (head_data[2*COORD_BITS-1:COORD_BITS]),
      .first_y    (head_data[COORD_BITS-1:0]),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .inside_res (rsp_inside_res)
   );

endmodule

// ----- verif/tb_point_in_polygon_parity.sv -----
`timescale 1ns / 1ps

module tb_point_in_polygon_parity;

   // Register byte addresses on the APB port.
   localparam logic [2:0] ADDR_POINT_X = 3'd0;
   localparam logic [2:0] ADDR_POINT_Y = 3'd4;

   localparam int COORD_MIN = 32'sh8000_0000;
   localparam int COORD_MAX = 32'sh7FFF_FFFF;

   // Queue (4) plus the stage-1, product and compare stages, with margin.
   localparam int PIPE_SETTLE  = 10;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int MAX_REPORTS  = 10;

   // How far random vertices stray from the test point.
   typedef enum int {RING_NEAR, RING_WIDE, RING_FULL} ring_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_vertex_x = '0;
   logic [31:0] req_vertex_y = '0;
   logic        req_last_vertex = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_inside_res;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Test point as the block should currently hold it.
   int test_pt_x = 0;
   int test_pt_y = 0;

   // Ring state mirrored from the block.
   int ring_first_x = 0;
   int ring_first_y = 0;
   int ring_prev_x  = 0;
   int ring_prev_y  = 0;
   bit ring_parity  = 1'b0;
   bit ring_open    = 1'b0;

   // Inside flags still owed by the block, oldest first.
   bit expected_inside[$];

   int send_gap_pct   = 0;
   int rsp_stall_pct  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   point_in_polygon_parity #(.COORD_BITS(32)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs or drops a result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_point_in_polygon_parity: done, errors");
         $finish;
      end
   end

   // True when the edge (x1,y1)->(x2,y2) crosses the horizontal line through the
   // test point (half-open in y) strictly to the right of the point. The division
   // is avoided: compare (px-x1)*dy with (py-y1)*dx, flipping the sense for
   // downward edges. Differences are 33 bits, products stay exact in 68 bits.
   function automatic bit crosses_left(int x1, int y1, int x2, int y2);
      logic signed [67:0] off_x, off_y, run_x, run_y, lhs, rhs;
      if (!((y1 <= test_pt_y && y2 > test_pt_y) || (y1 > test_pt_y && y2 <= test_pt_y)))
         return 1'b0;
      off_x = longint'(test_pt_x) - longint'(x1);
      off_y = longint'(test_pt_y) - longint'(y1);
      run_x = longint'(x2) - longint'(x1);
      run_y = longint'(y2) - longint'(y1);
      lhs = off_x * run_y;
      rhs = off_y * run_x;
      return (run_y > 0) ? (lhs < rhs) : (lhs > rhs);
   endfunction

   // Advance the ring state by one accepted vertex; on the last vertex close the
   // ring back to its first vertex and queue the inside flag.
   function automatic void step_ring(int vx, int vy, bit last);
      if (!ring_open) begin
         ring_first_x = vx;
         ring_first_y = vy;
         ring_parity  = 1'b0;
         ring_open    = 1'b1;
      end else begin
         ring_parity ^= crosses_left(ring_prev_x, ring_prev_y, vx, vy);
      end
      ring_prev_x = vx;
      ring_prev_y = vy;
      if (last) begin
         ring_parity ^= crosses_left(vx, vy, ring_first_x, ring_first_y);
         expected_inside.push_back(ring_parity);
         ring_parity = 1'b0;
         ring_open   = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $time, what);
   endtask

   // Check every accepted result against the oldest owed inside flag.
   always @(posedge clock) begin : check_results
      bit want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_inside.size() == 0) begin
            report_mismatch($sformatf("unexpected item, inside_res=%0b", rsp_inside_res));
         end else begin
            want = expected_inside.pop_front();
            if (rsp_inside_res !== want)
               report_mismatch($sformatf("inside_res expected %0b actual %0b",
                                         want, rsp_inside_res));
         end
      end
   end

   // Receiver side: stall at random, re-rolled every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Offer one vertex, after a random gap, and hold it until accepted.
   // Call and return on a falling edge; valid stays high for back-to-back items.
   task automatic send_vertex(int vx, int vy, bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= vx;
      req_vertex_y    <= vy;
      req_last_vertex <= last;
      do @(posedge clock); while (req_stall);
      step_ring(vx, vy, last);
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed result, then let the pipeline empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_inside.size() != 0) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic write_point_reg(logic [2:0] addr, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_POINT_X)
         test_pt_x = value;
      else
         test_pt_y = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_point(int px, int py);
      wait_idle();
      write_point_reg(ADDR_POINT_X, px);
      write_point_reg(ADDR_POINT_Y, py);
   endtask

   function automatic int pick_coord(int center, ring_style_type style);
      case (style)
         RING_NEAR: return center + int'($urandom_range(12)) - 6;
         RING_WIDE: return center + int'($urandom_range(2000)) - 1000;
         default:   return int'($urandom);
      endcase
   endfunction

   function automatic int pick_point_coord();
      case ($urandom_range(4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return int'($urandom);
         default: return int'($urandom_range(200)) - 100;
      endcase
   endfunction

   // A vertex that is also the last one: degenerate ring, always outside.
   task automatic test_single_vertex_rings();
      set_point(0, 0);
      send_vertex(5, -3, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
   endtask

   task automatic test_square();
      send_vertex(-10, -10, 1'b0);
      send_vertex(10, -10, 1'b0);
      send_vertex(10, 10, 1'b0);
      send_vertex(-10, 10, 1'b1);
   endtask

   // Ring closed by repeating its first vertex: the closing edge is empty.
   task automatic test_repeated_closing_vertex();
      send_vertex(-10, -10, 1'b0);
      send_vertex(10, -10, 1'b0);
      send_vertex(10, 10, 1'b0);
      send_vertex(-10, 10, 1'b0);
      send_vertex(-10, -10, 1'b1);
   endtask

   // Full-range coordinates and a test point sitting on a corner.
   task automatic test_extreme_coordinates();
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(0, COORD_MAX, 1'b1);
      set_point(COORD_MIN, COORD_MIN);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b1);
   endtask

   // Point exactly on an edge, then exactly on a vertex.
   task automatic test_on_edge_ties();
      set_point(0, 0);
      send_vertex(-3, -3, 1'b0);
      send_vertex(3, 3, 1'b0);
      send_vertex(3, -3, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(4, 0, 1'b0);
      send_vertex(4, 4, 1'b1);
   endtask

   // Move the point while a ring is open; later edges see the new point.
   task automatic test_point_moved_mid_ring();
      send_vertex(-10, -10, 1'b0);
      send_vertex(10, -10, 1'b0);
      wait_idle();
      write_point_reg(ADDR_POINT_X, 20);
      send_vertex(10, 10, 1'b0);
      send_vertex(-10, 10, 1'b1);
   endtask

   // Well-formed rings of random size and spread; now and then drain and move
   // the point, which also holds the sender until every result is back.
   task automatic test_random_rings(int n_items, int gap_pct, int stall_pct);
      int sent;
      int len;
      int k;
      int vx;
      int vy;
      int fx;
      int fy;
      ring_style_type style;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      fx = 0;
      fy = 0;
      while (sent < n_items) begin
         if ($urandom_range(39) == 0)
            set_point(pick_point_coord(), pick_point_coord());
         len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(10, 3);
         case ($urandom_range(9))
            0, 1:    style = RING_FULL;
            2, 3:    style = RING_WIDE;
            default: style = RING_NEAR;
         endcase
         for (k = 0; k < len; k++) begin
            vx = pick_coord(test_pt_x, style);
            vy = pick_coord(test_pt_y, style);
            if (k == 0) begin
               fx = vx;
               fy = vy;
            end else if (k == len - 1 && len > 2 && $urandom_range(7) == 0) begin
               vx = fx;
               vy = fy;
            end
            send_vertex(vx, vy, k == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily, through the directed part too.
      send_gap_pct  = 22;
      rsp_stall_pct = 59;
      test_single_vertex_rings();
      test_square();
      test_repeated_closing_vertex();
      test_extreme_coordinates();
      test_on_edge_ties();
      test_point_moved_mid_ring();

      set_point(0, 0);
      test_random_rings(580, 22, 59);
      set_point(COORD_MAX, COORD_MIN);
      test_random_rings(580, 59, 22);
      set_point(int'($urandom), int'($urandom));
      test_random_rings(580, 0, 0);

      wait_idle();
      if (mismatch_count == 0 && expected_inside.size() == 0)
         $display("tb_point_in_polygon_parity: done, clean");
      else
         $display("tb_point_in_polygon_parity: done, errors");
      $finish;
   end

endmodule
